// File: src/utf8_to_ucs2_decoder_macros.svh
// Assertion macros for the UTF-8 to UCS-2 decoder.
`ifndef UTF8_TO_UCS2_DECODER_MACROS_SVH
`define UTF8_TO_UCS2_DECODER_MACROS_SVH
`ifndef SYNTH
// Plain property, clocked on aclk, off during reset.
`define U2D_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);
// Same-cycle implication.
`define U2D_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define U2D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define U2D_ASSERT(lbl, prop, msg)
`define U2D_ASSERT_IMPL(lbl, ante, cons, msg)
`define U2D_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: src/utf8dec_pkg.sv
// Shared types and constants of the UTF-8 to UCS-2 decoder.
package utf8dec_pkg;

    localparam int DEFAULT_COUNT_BITS = 16;
    localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

    // Lead and continuation byte classes: (byte & MASK) == CODE
    localparam logic [7:0] ASCII_MASK = 8'h80;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] LEAD5_MASK = 8'hFC;
    localparam logic [7:0] LEAD5_CODE = 8'hF8;
    localparam logic [7:0] LEAD6_MASK = 8'hFE;
    localparam logic [7:0] LEAD6_CODE = 8'hFC;

    localparam logic [7:0] CONT_BITS  = 8'h3F;
    localparam logic [7:0] LEAD2_BITS = 8'h1F;
    localparam logic [7:0] LEAD3_BITS = 8'h0F;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [15:0] unit_index;
    } out_item_t;

    // Decoder to output buffer
    typedef struct packed {
        logic      valid;
        out_item_t data;
    } res_bus_t;

endpackage

// File: src/utf8dec_core.sv
// Input register, byte decoder state, unit counter and limit register.
`include "utf8_to_ucs2_decoder_macros.svh"

module utf8dec_core
    import utf8dec_pkg::*;
#(
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output res_bus_t    res,
    input  logic        res_ready
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_COLLECT,
        MODE_SKIP
    } mode_t;

    logic                  in_valid_reg;
    in_item_t              in_data_reg;
    logic [15:0]           out_limit_reg;
    mode_t                 mode_reg, mode_next;
    logic [2:0]            remain_reg, remain_next;
    logic [15:0]           partial_reg, partial_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic        advance;
    logic        lead;
    logic        done;
    logic        emit;
    logic [15:0] unit;
    logic [7:0]  b;
    logic [31:0] count_ext;
    logic [31:0] limit_ext;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && res_ready;
    assign s_ready   = !in_valid_reg || res_ready;
    assign b         = in_data_reg.byte_in;
    assign count_ext = 32'(count_reg);
    assign limit_ext = 32'(out_limit_reg);

    always_comb begin
        mode_next    = mode_reg;
        remain_next  = remain_reg;
        partial_next = partial_reg;
        count_next   = count_reg;
        lead         = 1'b0;
        done         = 1'b0;
        unit         = '0;

        case (mode_reg)
            MODE_COLLECT: begin
                if ((remain_reg == 3'd1 || remain_reg == 3'd2) &&
                    ((b & CONT_MASK) == CONT_CODE)) begin
                    remain_next = remain_reg - 3'd1;
                    if (remain_next == 3'd1) begin
                        partial_next = partial_reg | {4'b0, b[5:0] & CONT_BITS[5:0], 6'b0};
                    end else begin
                        partial_next = partial_reg | {10'b0, b[5:0] & CONT_BITS[5:0]};
                    end
                    if (remain_next == 3'd0) begin
                        mode_next = MODE_IDLE;
                        unit      = partial_next;
                        done      = 1'b1;
                    end
                end else begin
                    lead = 1'b1;
                end
            end
            MODE_SKIP: begin
                if (remain_reg != 3'd0) begin
                    remain_next = remain_reg - 3'd1;
                    if (remain_next == 3'd0) begin
                        mode_next = MODE_IDLE;
                    end
                end else begin
                    lead = 1'b1;
                end
            end
            default: begin
                lead = 1'b1;
            end
        endcase

        // Examine the byte as a lead; stray continuations and 0xFE/0xFF drop out
        if (lead) begin
            mode_next   = MODE_IDLE;
            remain_next = 3'd0;
            if ((b & ASCII_MASK) == 8'h00) begin
                unit = {8'b0, b};
                done = 1'b1;
            end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
                mode_next    = MODE_COLLECT;
                remain_next  = 3'd1;
                partial_next = {5'b0, b[4:0] & LEAD2_BITS[4:0], 6'b0};
            end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
                mode_next    = MODE_COLLECT;
                remain_next  = 3'd2;
                partial_next = {b[3:0] & LEAD3_BITS[3:0], 12'b0};
            end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
                mode_next   = MODE_SKIP;
                remain_next = 3'd3;
            end else if ((b & LEAD5_MASK) == LEAD5_CODE) begin
                mode_next   = MODE_SKIP;
                remain_next = 3'd4;
            end else if ((b & LEAD6_MASK) == LEAD6_CODE) begin
                mode_next   = MODE_SKIP;
                remain_next = 3'd5;
            end
        end

        // Hold the count at the limit or at its own maximum
        emit = done && (count_ext < limit_ext) && (count_reg != {COUNT_BITS{1'b1}});
        if (emit) begin
            count_next = count_reg + COUNT_BITS'(1);
        end

        if (in_data_reg.end_of_text) begin
            mode_next    = MODE_IDLE;
            remain_next  = 3'd0;
            partial_next = '0;
            count_next   = '0;
        end
    end

    assign res.valid           = advance && emit;
    assign res.data.code_unit  = unit;
    assign res.data.unit_index = count_ext[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_limit_reg <= LIMIT_RESET;
            mode_reg      <= MODE_IDLE;
            remain_reg    <= 3'd0;
            partial_reg   <= '0;
            count_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (cfg_valid && cfg_ready) begin
                out_limit_reg <= cfg_data;
            end
            if (advance) begin
                mode_reg    <= mode_next;
                remain_reg  <= remain_next;
                partial_reg <= partial_next;
                count_reg   <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    `U2D_ASSERT_IMPL(a_res_needs_item, res.valid, in_valid_reg && res_ready, "result without a held byte")
    `U2D_ASSERT_IMPL(a_collect_count, mode_reg == MODE_COLLECT, remain_reg == 3'd1 || remain_reg == 3'd2, "bad collect count")
    `U2D_ASSERT_IMPL(a_skip_count, mode_reg == MODE_SKIP, remain_reg != 3'd0, "skip with nothing left")
    `U2D_ASSERT_NEXT(a_eot_clears, advance && in_data_reg.end_of_text, count_reg == '0 && mode_reg == MODE_IDLE, "end of text did not clear")
    `U2D_ASSERT_IMPL(a_index_below_limit, res.valid, count_ext < limit_ext, "unit emitted past limit")

endmodule

// File: src/utf8dec_out_buf.sv
// Output register with skid stage for decoded code units.
module utf8dec_out_buf
    import utf8dec_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  res_bus_t  res,
    output logic      res_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      skid_valid_reg;
    out_item_t skid_data_reg;
    logic      push;
    logic      drain;

    assign res_ready = !skid_valid_reg;
    assign push      = res.valid && res_ready;
    assign drain     = !out_valid_reg || m_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (drain) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            // hold the new transaction while the receiver stalls
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (drain) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (push) begin
                out_data_reg <= res.data;
            end
        end else if (push) begin
            skid_data_reg <= res.data;
        end
    end

endmodule

// File: src/utf8_to_ucs2_decoder.sv
// Top level of the UTF-8 to UCS-2 decoder.
//
// Bytes enter on s_valid/s_ready/s_data, one per transaction, with an
// end_of_text flag on the last byte of a text. Decoded 16-bit code units
// leave on m_valid/m_ready/m_data with their position in the text.
// One-, two- and three-byte sequences produce a unit; four- to six-byte
// sequences, stray continuation bytes and 0xFE/0xFF produce none.
// cfg_valid/cfg_ready/cfg_data write the output limit; cfg_ready is always
// high. Write it only while no byte is in flight.
// Path: a unit is decoded from its final byte while that byte sits in the
// input register, and the unit is loaded into the output register (or
// into the skid stage while the receiver stalls).
// Throughput: one byte per cycle unless the output stalls; the decode step
// is one pass of logic between the input register and the output register.
// Reset clears the decoder state and the unit count and sets the limit to
// 65535; m_valid is low and s_ready high from the first clock edge in reset.
// When the receiver stalls, a skid stage takes one more unit and then
// s_ready falls until the output drains.
module utf8_to_ucs2_decoder
    import utf8dec_pkg::*;
#(
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    res_bus_t res;
    logic     res_ready;

    utf8dec_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .res       (res),
        .res_ready (res_ready)
    );

    utf8dec_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res       (res),
        .res_ready (res_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
